// ===== hdl/bal_pkg.sv =====
// Shared types and constants of the buddy allocator.
`default_nettype none
package bal_pkg;
  localparam int OW = 5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_RD_CUR,
    OP_SCAN,
    OP_SPLIT_PREP,
    OP_SPLIT,
    OP_MARK,
    OP_FAIL,
    OP_FREE_CLR_USED,
    OP_RD_BUDDY,
    OP_MERGE_HI,
    OP_MERGE_LO,
    OP_FREE_OK
  } op_t;

  typedef struct packed {
    logic clr_done;
    logic kind;
    logic want_bad;
    logic addr_bad;
    logic cur_end;
    logic found;
    logic need_split;
    logic ent_used;
    logic can_climb;
    logic can_merge;
    logic out_full;
  } sts_t;
endpackage
`default_nettype wire

// ===== hdl/buddy_allocator_top.sv =====
// Top level of the binary buddy allocator.
// Each request on the in_ channel either allocates (kind 0) a block of
// request_size units, rounded up to a power of two, or frees (kind 1) the
// used block that starts at free_address. Every request gives exactly one
// result on the out_ channel: ok, block_address and grant_size.
// After reset the block table is cleared one entry per cycle, and in_stall
// stays high during that pass.
// One request is worked on at a time. An allocate walks the block list
// through the table RAM read port, reading each block and then evaluating
// it, then splits the best block down to the wanted size, ends the
// splitting and marks the block. A free clears the used flag of its block
// and then reads and checks the buddy and merges, until a buddy or the
// top order stops the merging. A result waits in the output register while
// out_stall is high; the next request can be taken meanwhile, and its
// result is held back until the output register is free.
`default_nettype none
module buddy_allocator_top #(
  parameter int POOL_ORDER = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [10:0] in_request_size,
  input  wire logic [9:0]  in_free_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic      [9:0]  out_block_address,
  output logic      [10:0] out_grant_size
);
  bal_pkg::op_t  op;
  bal_pkg::sts_t sts;

  bal_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .sts(sts),
    .in_stall(in_stall), .op(op)
  );

  bal_datapath #(.POOL_ORDER(POOL_ORDER)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op),
    .in_kind(in_kind), .in_request_size(in_request_size),
    .in_free_address(in_free_address), .out_stall(out_stall),
    .out_valid(out_valid), .out_ok(out_ok),
    .out_block_address(out_block_address), .out_grant_size(out_grant_size),
    .sts(sts)
  );
endmodule
`default_nettype wire

// ===== hdl/bal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bal_ram #(
  parameter int W = 6,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/bal_datapath.sv =====
// Datapath of the buddy allocator: block table, scan, split, merge and result registers.
`default_nettype none
module bal_datapath #(
  parameter int POOL_ORDER = 10
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire bal_pkg::op_t op,
  input  wire logic         in_kind,
  input  wire logic [10:0]  in_request_size,
  input  wire logic [9:0]   in_free_address,
  input  wire logic         out_stall,
  output logic              out_valid,
  output logic              out_ok,
  output logic      [9:0]   out_block_address,
  output logic      [10:0]  out_grant_size,
  output bal_pkg::sts_t     sts
);
  localparam int AW = POOL_ORDER;
  localparam int OW = bal_pkg::OW;
  localparam logic [OW-1:0] MAX_CODE = OW'(POOL_ORDER + 1);
  localparam logic [OW-1:0] MAX_ORD = OW'(POOL_ORDER);

  logic          kind_r, want_bad_r, addr_bad_r;
  logic [OW-1:0] want_r, best_ord_r, ord_r;
  logic [AW:0]   cur_r;
  logic [AW-1:0] best_r, clr_r;
  logic          out_valid_r, out_ok_r;
  logic [9:0]    out_addr_r;
  logic [10:0]   out_size_r;

  logic          kind_nxt, want_bad_nxt, addr_bad_nxt;
  logic [OW-1:0] want_nxt, best_ord_nxt, ord_nxt;
  logic [AW:0]   cur_nxt;
  logic [AW-1:0] best_nxt, clr_nxt;
  logic          out_valid_nxt, out_ok_nxt;
  logic [9:0]    out_addr_nxt;
  logic [10:0]   out_size_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr, bit_ord;
  logic [5:0]    wdata, rdata;
  logic [OW-1:0] code, ent_ord, want_c;
  logic          code_ok, want_bad_c;
  logic [31:0]   req32, best32, size32;

  bal_ram #(.W(6), .D(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign code    = rdata[OW-1:0];
  assign code_ok = (code != '0) && (code <= MAX_CODE);
  assign ent_ord = code - OW'(1);
  assign bit_ord = AW'(1) << ord_r;
  assign req32   = (in_request_size == '0) ? 32'd1 : 32'(in_request_size);
  assign best32  = 32'(best_r);
  assign size32  = 32'd1 << want_r;

  always_comb begin
    want_c     = MAX_ORD;
    want_bad_c = (32'd1 << POOL_ORDER) < req32;
    for (int w = POOL_ORDER; w >= 0; w--) begin
      if ((32'd1 << w) >= req32) begin
        want_c = OW'(w);
      end
    end
  end

  always_comb begin
    kind_nxt      = kind_r;
    want_bad_nxt  = want_bad_r;
    addr_bad_nxt  = addr_bad_r;
    want_nxt      = want_r;
    best_ord_nxt  = best_ord_r;
    ord_nxt       = ord_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_addr_nxt  = out_addr_r;
    out_size_nxt  = out_size_r;
    we            = 1'b0;
    waddr         = cur_r[AW-1:0];
    wdata         = '0;
    raddr         = cur_r[AW-1:0];
    case (op)
      bal_pkg::OP_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = (clr_r == '0) ? {1'b0, MAX_CODE} : '0;
        clr_nxt = clr_r + AW'(1);
      end
      bal_pkg::OP_LOAD: begin
        kind_nxt     = in_kind;
        want_nxt     = want_c;
        want_bad_nxt = want_bad_c;
        addr_bad_nxt = 32'(in_free_address) >= (32'd1 << POOL_ORDER);
        best_ord_nxt = MAX_CODE;
        cur_nxt      = in_kind ? (AW+1)'(in_free_address) : '0;
      end
      bal_pkg::OP_SCAN: begin
        if (code_ok) begin
          if (!rdata[5] && ent_ord >= want_r && ent_ord < best_ord_r) begin
            best_ord_nxt = ent_ord;
            best_nxt     = cur_r[AW-1:0];
          end
          cur_nxt = cur_r + ((AW+1)'(1) << ent_ord);
        end else begin
          cur_nxt = cur_r + (AW+1)'(1);
        end
      end
      bal_pkg::OP_SPLIT_PREP: begin
        ord_nxt = best_ord_r;
      end
      bal_pkg::OP_SPLIT: begin
        ord_nxt = ord_r - OW'(1);
        we      = 1'b1;
        waddr   = best_r + (AW'(1) << ord_nxt);
        wdata   = {1'b0, ord_r};
      end
      bal_pkg::OP_MARK: begin
        we            = 1'b1;
        waddr         = best_r;
        wdata         = {1'b1, want_r + OW'(1)};
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_addr_nxt  = best32[9:0];
        out_size_nxt  = size32[10:0];
      end
      bal_pkg::OP_FAIL: begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b0;
        out_addr_nxt  = '0;
        out_size_nxt  = '0;
      end
      bal_pkg::OP_FREE_CLR_USED: begin
        we      = 1'b1;
        wdata   = {1'b0, code};
        ord_nxt = ent_ord;
      end
      bal_pkg::OP_RD_BUDDY: begin
        raddr = cur_r[AW-1:0] ^ bit_ord;
      end
      bal_pkg::OP_MERGE_HI: begin
        we    = 1'b1;
        waddr = cur_r[AW-1:0] | bit_ord;
      end
      bal_pkg::OP_MERGE_LO: begin
        we      = 1'b1;
        waddr   = cur_r[AW-1:0] & ~bit_ord;
        wdata   = {1'b0, ord_r + OW'(2)};
        cur_nxt = {1'b0, cur_r[AW-1:0] & ~bit_ord};
        ord_nxt = ord_r + OW'(1);
      end
      bal_pkg::OP_FREE_OK: begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_addr_nxt  = '0;
        out_size_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
    end
    kind_r     <= kind_nxt;
    want_bad_r <= want_bad_nxt;
    addr_bad_r <= addr_bad_nxt;
    want_r     <= want_nxt;
    best_ord_r <= best_ord_nxt;
    ord_r      <= ord_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    out_ok_r   <= out_ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_size_r <= out_size_nxt;
  end

  assign sts.clr_done   = &clr_r;
  assign sts.kind       = kind_r;
  assign sts.want_bad   = want_bad_r;
  assign sts.addr_bad   = addr_bad_r;
  assign sts.cur_end    = cur_r[AW];
  assign sts.found      = best_ord_r <= MAX_ORD;
  assign sts.need_split = ord_r > want_r;
  assign sts.ent_used   = code_ok && rdata[5];
  assign sts.can_climb  = ord_r < MAX_ORD;
  assign sts.can_merge  = !rdata[5] && (code == ord_r + OW'(1));
  assign sts.out_full   = out_valid_r && out_stall;

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_block_address = out_addr_r;
  assign out_grant_size    = out_size_r;
endmodule
`default_nettype wire

// ===== hdl/bal_ctrl.sv =====
// Controller state machine of the buddy allocator.
`default_nettype none
module bal_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire bal_pkg::sts_t sts,
  output logic               in_stall,
  output bal_pkg::op_t       op
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START, S_SCAN_RD, S_SCAN_EV, S_ADEC, S_SPLIT, S_MARK,
    S_FCHK, S_FBRD, S_FBCHK, S_FMLO, S_FOK, S_FAIL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = bal_pkg::OP_NONE;
    unique case (state_r)
      S_CLR: begin
        op = bal_pkg::OP_CLR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = bal_pkg::OP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (!sts.kind) begin
          state_nxt = sts.want_bad ? S_FAIL : S_SCAN_RD;
        end else if (sts.addr_bad) begin
          state_nxt = S_FAIL;
        end else begin
          op        = bal_pkg::OP_RD_CUR;
          state_nxt = S_FCHK;
        end
      end
      S_SCAN_RD: begin
        if (sts.cur_end) begin
          state_nxt = S_ADEC;
        end else begin
          op        = bal_pkg::OP_RD_CUR;
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        op        = bal_pkg::OP_SCAN;
        state_nxt = S_SCAN_RD;
      end
      S_ADEC: begin
        if (sts.found) begin
          op        = bal_pkg::OP_SPLIT_PREP;
          state_nxt = S_SPLIT;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_SPLIT: begin
        if (sts.need_split) op = bal_pkg::OP_SPLIT;
        else state_nxt = S_MARK;
      end
      S_MARK: begin
        if (!sts.out_full) begin
          op        = bal_pkg::OP_MARK;
          state_nxt = S_IDLE;
        end
      end
      S_FCHK: begin
        if (sts.ent_used) begin
          op        = bal_pkg::OP_FREE_CLR_USED;
          state_nxt = S_FBRD;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_FBRD: begin
        if (sts.can_climb) begin
          op        = bal_pkg::OP_RD_BUDDY;
          state_nxt = S_FBCHK;
        end else begin
          state_nxt = S_FOK;
        end
      end
      S_FBCHK: begin
        if (sts.can_merge) begin
          op        = bal_pkg::OP_MERGE_HI;
          state_nxt = S_FMLO;
        end else begin
          state_nxt = S_FOK;
        end
      end
      S_FMLO: begin
        op        = bal_pkg::OP_MERGE_LO;
        state_nxt = S_FBRD;
      end
      S_FOK: begin
        if (!sts.out_full) begin
          op        = bal_pkg::OP_FREE_OK;
          state_nxt = S_IDLE;
        end
      end
      S_FAIL: begin
        if (!sts.out_full) begin
          op        = bal_pkg::OP_FAIL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
endmodule
`default_nettype wire
